[sv/dta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_pkg
// Shared types and constants of the debounced threshold alarm table.
// ----------------------------------------------------------------------------
package dta_pkg;

   localparam int NUM_RULES  = 16;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(NUM_RULES);
   localparam int CNT_BITS   = $clog2(NUM_RULES + 1);
   localparam int TIME_BITS  = 32;
   localparam int QDEPTH     = 2;

   typedef enum logic [2:0] {
      REQ_ADD     = 3'd0,
      REQ_EVAL    = 3'd1,
      REQ_ENABLE  = 3'd2,
      REQ_DISABLE = 3'd3,
      REQ_REMOVE  = 3'd4,
      REQ_CLEAR   = 3'd5,
      REQ_LIST    = 3'd6,
      REQ_NONE    = 3'd7
   } req_code_type;

   typedef enum logic [2:0] {
      OP_GT  = 3'd0,
      OP_LT  = 3'd1,
      OP_GTE = 3'd2,
      OP_LTE = 3'd3,
      OP_EQ  = 3'd4,
      OP_NE  = 3'd5
   } cmp_op_type;

   typedef enum logic [1:0] {
      KIND_DONE  = 2'd0,
      KIND_EVAL  = 2'd1,
      KIND_ENTRY = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   // list-walk actions handed from the front to the back
   typedef enum logic [1:0] {
      LACT_NONE = 2'd0,
      LACT_ADD  = 2'd1,
      LACT_DROP = 2'd2,
      LACT_LIST = 2'd3
   } lact_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_SCAN = 2'd1,
      BK_EMIT = 2'd2
   } bk_state_type;

   typedef struct packed {
      lact_type              lact;
      logic [IDX_BITS-1:0]   idx;
      logic                  clear;
      kind_type              kind;
      logic                  act;
      // raised rules at the time of a list query
      logic [NUM_RULES-1:0]  mask;
   } job_type;

endpackage : dta_pkg
`default_nettype wire

[sv/dta_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_req_if / dta_rsp_if
// Valid/ready channels of the alarm table.
// ----------------------------------------------------------------------------
interface dta_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [3:0]  rule_index;
   logic signed [31:0] sample_value;
   logic signed [31:0] threshold;
   logic [2:0]  compare_op;
   logic signed [31:0] debounce_time;
   logic [31:0] now_ms;
   modport source (output valid, req_type, rule_index, sample_value, threshold,
                   compare_op, debounce_time, now_ms, input ready);
   modport sink   (input valid, req_type, rule_index, sample_value, threshold,
                   compare_op, debounce_time, now_ms, output ready);
endinterface

interface dta_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic       alarm_active;
   logic [3:0] rule_out;
   logic       last;
   modport source (output valid, result_kind, alarm_active, rule_out, last, input ready);
   modport sink   (input valid, result_kind, alarm_active, rule_out, last, output ready);
endinterface
`default_nettype wire

[sv/debounced_threshold_alarm_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_threshold_alarm_table
// Alarm rule table with debounce and an ordered list of rules for listing raised alarms.
//
//   channel | dir | handshake   | payload
//   req_    | in  | valid/ready | request code, rule slot, sample, rule, time
//   rsp_    | out | valid/ready | result kind, alarm, listed rule, last
//
// Front end evaluates a request in its accept cycle; a two-deep job queue
// feeds the list walker, which takes a job when idle. In the walker add and
// drop walk every listed rule (up to 16) before they answer; a list query
// walks the entries up to the last raised one; other requests answer without
// a walk. Sync reset empties table and list.
// A stalled result holds the walker; the queue lets the front go on while it has room.
// ----------------------------------------------------------------------------
module debounced_threshold_alarm_table (
   input  wire logic clock,
   input  wire logic reset,
   dta_req_if.sink   req,
   dta_rsp_if.source rsp
);

   dta_pkg::job_type f_job, b_job;
   logic f_valid, f_ready, b_valid, b_ready;

   dta_front u_front (
      .clock, .reset, .req,
      .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
   );

   dta_queue u_queue (
      .clock, .reset,
      .in_job(f_job), .in_valid(f_valid), .in_ready(f_ready),
      .out_job(b_job), .out_valid(b_valid), .out_ready(b_ready)
   );

   dta_back u_back (
      .clock, .reset,
      .job(b_job), .job_valid(b_valid), .job_ready(b_ready), .rsp
   );

endmodule : debounced_threshold_alarm_table
`default_nettype wire

[sv/dta_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_front
// Decodes requests, keeps the rule table and evaluates alarms; hands the
// list work and the answer to the back end as a job.
// ----------------------------------------------------------------------------
module dta_front (
   input  wire logic         clock,
   input  wire logic         reset,
   dta_req_if.sink           req,
   output dta_pkg::job_type  job,
   output logic              job_valid,
   input  wire logic         job_ready
);

   localparam int IB = dta_pkg::IDX_BITS;
   localparam int VB = dta_pkg::VALUE_BITS;
   localparam int TB = dta_pkg::TIME_BITS;

   logic [dta_pkg::NUM_RULES-1:0] present_ff, enabled_ff, alarm_ff;
   logic [TB-1:0]  met_ff   [dta_pkg::NUM_RULES];
   logic [2:0]     cmp_ff   [dta_pkg::NUM_RULES];
   logic [VB-1:0]  thr_ff   [dta_pkg::NUM_RULES];
   logic [TB-2:0]  deb_ff   [dta_pkg::NUM_RULES];

   logic                idx_ok, known, met, fire, take;
   logic [IB-1:0]       r;
   logic [VB-1:0]       skey, tkey;
   logic [TB-1:0]       stamp, elapsed;
   dta_pkg::req_code_type code;
   dta_pkg::job_type    j;

   assign take      = req.valid & req.ready;
   assign req.ready = job_ready;
   assign job_valid = req.valid;
   assign job       = j;

   assign code   = dta_pkg::req_code_type'(req.req_type);
   assign idx_ok = 32'(req.rule_index) < dta_pkg::NUM_RULES;
   assign r      = IB'(req.rule_index);
   assign known  = idx_ok & present_ff[r];
   // offset-binary keys give signed order through unsigned compare
   assign skey   = VB'(req.sample_value) ^ {1'b1, {(VB-1){1'b0}}};
   assign tkey   = thr_ff[r] ^ {1'b1, {(VB-1){1'b0}}};

   always_comb begin
      unique case (cmp_ff[r])
         dta_pkg::OP_GT:  met = skey >  tkey;
         dta_pkg::OP_LT:  met = skey <  tkey;
         dta_pkg::OP_GTE: met = skey >= tkey;
         dta_pkg::OP_LTE: met = skey <= tkey;
         dta_pkg::OP_EQ:  met = skey == tkey;
         dta_pkg::OP_NE:  met = skey != tkey;
         default:         met = 1'b0;
      endcase
   end

   assign stamp   = (met_ff[r] == '0) ? req.now_ms : met_ff[r];
   assign elapsed = req.now_ms - stamp;
   assign fire    = (deb_ff[r] == '0) || (elapsed >= {1'b0, deb_ff[r]});

   always_comb begin
      j       = '0;
      j.idx   = r;
      j.kind  = dta_pkg::KIND_DONE;
      unique case (code)
         dta_pkg::REQ_ADD:     if (idx_ok) j.lact = dta_pkg::LACT_ADD;
         dta_pkg::REQ_EVAL: begin
            j.kind = dta_pkg::KIND_EVAL;
            if (known) begin
               if (!enabled_ff[r]) j.lact = dta_pkg::LACT_DROP;
               else if (met) begin
                  j.act = alarm_ff[r] | fire;
                  if (fire & ~alarm_ff[r]) j.lact = dta_pkg::LACT_ADD;
               end else if (alarm_ff[r]) j.lact = dta_pkg::LACT_DROP;
            end
         end
         dta_pkg::REQ_DISABLE,
         dta_pkg::REQ_REMOVE:  if (known) j.lact = dta_pkg::LACT_DROP;
         dta_pkg::REQ_CLEAR:   j.clear = 1'b1;
         dta_pkg::REQ_LIST: begin
            j.lact = dta_pkg::LACT_LIST;
            j.mask = present_ff & alarm_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         enabled_ff <= '0;
         alarm_ff   <= '0;
         for (int i = 0; i < dta_pkg::NUM_RULES; i++) met_ff[i] <= '0;
      end else if (take) begin
         unique case (code)
            dta_pkg::REQ_ADD: if (idx_ok) begin
               present_ff[r] <= 1'b1;
               enabled_ff[r] <= 1'b1;
               alarm_ff[r]   <= 1'b0;
               met_ff[r]     <= '0;
               cmp_ff[r]     <= req.compare_op;
               thr_ff[r]     <= VB'(req.threshold);
               deb_ff[r]     <= req.debounce_time[TB-1] ? '0 : req.debounce_time[TB-2:0];
            end
            dta_pkg::REQ_EVAL: if (known) begin
               if (!enabled_ff[r] || !met) begin
                  met_ff[r]   <= '0;
                  alarm_ff[r] <= 1'b0;
               end else begin
                  met_ff[r] <= stamp;
                  if (fire) alarm_ff[r] <= 1'b1;
               end
            end
            dta_pkg::REQ_ENABLE: if (known && !enabled_ff[r]) begin
               enabled_ff[r] <= 1'b1;
               met_ff[r]     <= '0;
               alarm_ff[r]   <= 1'b0;
            end
            dta_pkg::REQ_DISABLE: if (known) begin
               enabled_ff[r] <= 1'b0;
               met_ff[r]     <= '0;
               alarm_ff[r]   <= 1'b0;
            end
            dta_pkg::REQ_REMOVE: if (known) begin
               present_ff[r] <= 1'b0;
               enabled_ff[r] <= 1'b0;
               met_ff[r]     <= '0;
               alarm_ff[r]   <= 1'b0;
            end
            dta_pkg::REQ_CLEAR: begin
               present_ff <= '0;
               enabled_ff <= '0;
               alarm_ff   <= '0;
               for (int i = 0; i < dta_pkg::NUM_RULES; i++) met_ff[i] <= '0;
            end
            default: ;
         endcase
      end
   end

endmodule : dta_front
`default_nettype wire

[sv/dta_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module dta_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  dta_pkg::job_type  in_job,
   input  wire logic         in_valid,
   output logic              in_ready,
   output dta_pkg::job_type  out_job,
   output logic              out_valid,
   input  wire logic         out_ready
);

   localparam int QB = $clog2(dta_pkg::QDEPTH);

   dta_pkg::job_type   mem_ff [dta_pkg::QDEPTH];
   logic [QB-1:0]      wr_ff, rd_ff;
   logic [QB:0]        cnt_ff;
   logic               push, pop;

   assign in_ready  = 32'(cnt_ff) < dta_pkg::QDEPTH;
   assign out_valid = cnt_ff != '0;
   assign out_job   = mem_ff[rd_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QB+1)'(push) - (QB+1)'(pop);
      end
   end

endmodule : dta_queue
`default_nettype wire

[sv/dta_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_back
// Keeps the ordered alarm list; walks it one entry a cycle for add, drop and
// list queries (list only while results are free); drives the result channel.
// ----------------------------------------------------------------------------
module dta_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  dta_pkg::job_type  job,
   input  wire logic         job_valid,
   output logic              job_ready,
   dta_rsp_if.source         rsp
);

   localparam int IB = dta_pkg::IDX_BITS;
   localparam int CB = dta_pkg::CNT_BITS;

   // the list also holds added rules that are not raised; a list query carries
   // the raised set and stops once every raised rule has been sent, since a
   // raised rule is always listed
   logic [IB-1:0]      list_ff [dta_pkg::NUM_RULES];
   logic [CB-1:0]      count_ff, count_in;
   logic [CB-1:0]      pos_ff, pos_in;
   logic               found_ff, found_in;
   dta_pkg::bk_state_type state_ff, state_in;
   dta_pkg::job_type   job_ff, job_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic               act_ff, act_in, last_ff, last_in;
   logic [IB-1:0]      rout_ff, rout_in;

   logic               at_end, hit, out_free, do_shift, do_app;
   logic [IB-1:0]      cur;
   logic [dta_pkg::NUM_RULES-1:0] rest;

   assign out_free = ~rsp_valid_ff | rsp.ready;
   assign at_end   = pos_ff >= count_ff;
   assign cur      = list_ff[pos_ff[IB-1:0]];
   assign hit      = ~at_end && cur == job_ff.idx;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dta_pkg::BK_IDLE:
            if (job_valid) begin
               if (job.clear || job.lact == dta_pkg::LACT_NONE) state_in = dta_pkg::BK_EMIT;
               else                                             state_in = dta_pkg::BK_SCAN;
            end
         dta_pkg::BK_SCAN:
            if (job_ff.lact == dta_pkg::LACT_LIST) begin
               if (out_free && (job_ff.mask == '0 || at_end)) state_in = dta_pkg::BK_IDLE;
            end else if (at_end) state_in = dta_pkg::BK_EMIT;
         dta_pkg::BK_EMIT:
            if (out_free) state_in = dta_pkg::BK_IDLE;
         default: state_in = dta_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      job_ready    = state_ff == dta_pkg::BK_IDLE;
      job_in       = job_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      do_shift     = 1'b0;
      do_app       = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      kind_in      = kind_ff;
      act_in       = act_ff;
      last_in      = last_ff;
      rout_in      = rout_ff;
      rest         = job_ff.mask;
      rest[cur]    = 1'b0;
      unique case (state_ff)
         dta_pkg::BK_IDLE:
            if (job_valid) begin
               job_in   = job;
               pos_in   = '0;
               found_in = 1'b0;
               if (job.clear) count_in = '0;
            end
         dta_pkg::BK_SCAN: begin
            if (job_ff.lact == dta_pkg::LACT_LIST) begin
               if (out_free) begin
                  if (job_ff.mask == '0) begin
                     // nothing raised: a single empty answer
                     if (!found_ff) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = dta_pkg::KIND_EMPTY;
                        act_in       = 1'b0;
                        rout_in      = '0;
                        last_in      = 1'b1;
                     end
                  end else if (!at_end) begin
                     pos_in = pos_ff + 1'b1;
                     if (job_ff.mask[cur]) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = dta_pkg::KIND_ENTRY;
                        act_in       = 1'b0;
                        rout_in      = cur;
                        last_in      = rest == '0;
                        job_in.mask  = rest;
                        found_in     = 1'b1;
                     end
                  end
               end
            end else if (!at_end) begin
               if (hit) found_in = 1'b1;
               if ((hit | found_ff) && job_ff.lact == dta_pkg::LACT_DROP) do_shift = 1'b1;
               pos_in = pos_ff + 1'b1;
            end else begin
               if (job_ff.lact == dta_pkg::LACT_ADD && !found_ff &&
                   32'(count_ff) < dta_pkg::NUM_RULES) begin
                  do_app   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (job_ff.lact == dta_pkg::LACT_DROP && found_ff) count_in = count_ff - 1'b1;
            end
         end
         dta_pkg::BK_EMIT:
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = job_ff.kind;
               act_in       = job_ff.act;
               rout_in      = '0;
               last_in      = 1'b1;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_shift && 32'(pos_ff) + 1 < dta_pkg::NUM_RULES)
         list_ff[pos_ff[IB-1:0]] <= list_ff[IB'(pos_ff + 1'b1)];
      if (do_app) list_ff[count_ff[IB-1:0]] <= job_ff.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dta_pkg::BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff   <= job_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      kind_ff  <= kind_in;
      act_ff   <= act_in;
      last_ff  <= last_in;
      rout_ff  <= rout_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_kind  = kind_ff;
   assign rsp.alarm_active = act_ff;
   assign rsp.rule_out     = 4'(rout_ff);
   assign rsp.last         = last_ff;

endmodule : dta_back
`default_nettype wire

[sv/dta_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_checker
// Port-level checks of the alarm table.
// ----------------------------------------------------------------------------
module dta_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic       rsp_act,
   input wire logic [3:0] rsp_rule,
   input wire logic       rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_rule))
      else $error("result changed while stalled");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != dta_pkg::KIND_ENTRY |-> rsp_last)
      else $error("single result without last");

   a_act: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != dta_pkg::KIND_EVAL |-> !rsp_act)
      else $error("alarm bit outside an evaluate answer");

   a_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != dta_pkg::KIND_ENTRY |-> rsp_rule == '0)
      else $error("rule index outside a list entry");

endmodule : dta_checker

bind debounced_threshold_alarm_table dta_checker u_dta_checker (
   .clock, .reset,
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.result_kind),
   .rsp_act(rsp.alarm_active), .rsp_rule(rsp.rule_out), .rsp_last(rsp.last)
);
`default_nettype wire
